// File: rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared constants, codes and item types of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 6;
    localparam int ENT_W       = 7;

    typedef enum logic [2:0] {
        ACT_APPEND   = 3'd0,
        ACT_LOOKUP   = 3'd1,
        ACT_SET      = 3'd2,
        ACT_WITHDRAW = 3'd3,
        ACT_CLEAR    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [15:0] key;
        logic [7:0]  value_a;
        logic [7:0]  value_b;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] position;
        logic [7:0]       found_value_a;
        logic [7:0]       found_value_b;
        logic [8:0]       average_doubled;
        logic [ENT_W-1:0] entries;
    } t_out_item;

    typedef struct packed {
        logic [15:0] key;
        logic [7:0]  value_a;
        logic [7:0]  value_b;
    } t_record;

endpackage

// File: rtl/core/sorted_key_table_search_delete.sv
// ----------------------------------------------------------------------------
// Sorted key table with search and withdraw
// Keyed records in ascending order with binary search, update and removal.
// ----------------------------------------------------------------------------
// One item is handled at a time, and each item gives one result item. The
// records sit in a single-port-read memory, so every probe of the binary
// search is an address step followed by a compare of the registered data.
// Append, clear and unused actions go from execution straight to the result.
// Lookup, set values and withdraw make at most log2(TABLE_DEPTH) + 1 probes;
// a key that is not found ends with one more search step on an empty range.
// Withdraw then moves each later entry down by one, a read and a write each.
// A result that waits in the output register does not stop the next item
// being accepted.
module sorted_key_table_search_delete
    import skt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } t_state;

    t_state           r_state;
    t_action          r_act;
    logic [15:0]      r_key;
    logic [7:0]       r_va;
    logic [7:0]       r_vb;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_hi;
    logic [IDX_W-1:0] r_mid;
    logic [IDX_W-1:0] r_i;
    t_out_item        r_res;
    t_out_item        r_out;
    logic             r_out_valid;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_record          ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_record          w_rec;
    logic [CNT_W:0]   w_sum;
    logic [IDX_W-1:0] w_mid;
    logic             w_out_free;
    logic [CNT_W:0]   w_i_next2;
    logic [CNT_W:0]   w_mid_next2;

    function automatic t_out_item make_res(input t_status st, input logic [IDX_W-1:0] pos,
                                           input logic [7:0] va, input logic [7:0] vb,
                                           input logic [CNT_W-1:0] cnt);
        t_out_item res;
        res.status          = st;
        res.position        = POS_W'(pos);
        res.found_value_a   = va;
        res.found_value_b   = vb;
        res.average_doubled = {1'b0, va} + {1'b0, vb};
        res.entries         = ENT_W'(cnt);
        return res;
    endfunction

    skt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH ($bits(t_record))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (w_rec)
    );

    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi} - (CNT_W + 1)'(1);
    assign w_mid       = w_sum[IDX_W:1];
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_i_next2   = (CNT_W + 1)'(r_i) + (CNT_W + 1)'(2);
    assign w_mid_next2 = (CNT_W + 1)'(r_mid) + (CNT_W + 1)'(2);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_mid;
        ram_wdata = '{key: r_key, value_a: r_va, value_b: r_vb};
        ram_raddr = r_mid;
        case (r_state)
            S_EXEC: begin
                if (r_act == ACT_APPEND && r_count < CNT_W'(TABLE_DEPTH)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IDX_W-1:0];
                end
            end
            S_SRCH: begin
                ram_raddr = w_mid;
            end
            S_CMP: begin
                if (r_act == ACT_SET && w_rec.key == r_key) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{key: w_rec.key, value_a: r_va, value_b: r_vb};
                end
            end
            S_SH_RD: begin
                ram_raddr = r_i + IDX_W'(1);
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = w_rec;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act   <= i_in_item.action;
                        r_key   <= i_in_item.key;
                        r_va    <= i_in_item.value_a;
                        r_vb    <= i_in_item.value_b;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_lo <= '0;
                    r_hi <= r_count;
                    case (r_act)
                        ACT_APPEND: begin
                            if (r_count < CNT_W'(TABLE_DEPTH)) begin
                                r_res   <= make_res(ST_OK, r_count[IDX_W-1:0], 8'd0, 8'd0,
                                                    r_count + CNT_W'(1));
                                r_count <= r_count + CNT_W'(1);
                            end else begin
                                r_res <= make_res(ST_FULL, '0, 8'd0, 8'd0, r_count);
                            end
                            r_state <= S_RESP;
                        end
                        ACT_LOOKUP, ACT_SET, ACT_WITHDRAW: begin
                            r_state <= S_SRCH;
                        end
                        ACT_CLEAR: begin
                            r_count <= '0;
                            r_res   <= make_res(ST_OK, '0, 8'd0, 8'd0, '0);
                            r_state <= S_RESP;
                        end
                        default: begin
                            r_res   <= make_res(ST_OK, '0, 8'd0, 8'd0, r_count);
                            r_state <= S_RESP;
                        end
                    endcase
                end
                S_SRCH: begin
                    if (r_lo >= r_hi) begin
                        r_res   <= make_res(ST_NOT_FOUND, '0, 8'd0, 8'd0, r_count);
                        r_state <= S_RESP;
                    end else begin
                        r_mid   <= w_mid;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_rec.key < r_key) begin
                        r_lo    <= CNT_W'(r_mid) + CNT_W'(1);
                        r_state <= S_SRCH;
                    end else if (w_rec.key > r_key) begin
                        r_hi    <= CNT_W'(r_mid);
                        r_state <= S_SRCH;
                    end else begin
                        case (r_act)
                            ACT_SET: begin
                                r_res   <= make_res(ST_OK, r_mid, r_va, r_vb, r_count);
                                r_state <= S_RESP;
                            end
                            ACT_WITHDRAW: begin
                                r_res   <= make_res(ST_OK, r_mid, w_rec.value_a, w_rec.value_b,
                                                    r_count - CNT_W'(1));
                                r_count <= r_count - CNT_W'(1);
                                r_i     <= r_mid;
                                if (w_mid_next2 <= {1'b0, r_count}) begin
                                    r_state <= S_SH_RD;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                            default: begin
                                r_res   <= make_res(ST_OK, r_mid, w_rec.value_a, w_rec.value_b,
                                                    r_count);
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    r_i <= r_i + IDX_W'(1);
                    if (w_i_next2 <= {1'b0, r_count}) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("Accepted item did not start execution.");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_hi <= r_count))
        else $error("Search range reaches beyond the held entries.");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR) |-> ((CNT_W + 1)'(r_i) + (CNT_W + 1)'(1) <= {1'b0, r_count}))
        else $error("Shift writes beyond the held entries.");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_NOT_FOUND) |->
        (o_out_item.position == '0 && o_out_item.average_doubled == '0))
        else $error("Not-found result carries a position or values.");

endmodule

// File: rtl/core/skt_ram.sv
// ----------------------------------------------------------------------------
// Sorted key table record memory
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/sorted_key_table_search_delete_test.sv
// ----------------------------------------------------------------------------
// Sorted key table search and withdraw testbench
// Drives append, lookup, set-values, withdraw, clear and unused-code items
// through the valid/ready handshakes with random idling and one long output
// hold-off, predicts every result from a private copy of the table, and checks
// each result item field by field in order.
// ----------------------------------------------------------------------------
module sorted_key_table_search_delete_test;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int TOTAL_ITEMS  = 1400;
    localparam int CALM_TAIL    = 150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        gen_keys[$];

    logic [15:0] table_key [TABLE_DEPTH];
    logic [7:0]  table_va  [TABLE_DEPTH];
    logic [7:0]  table_vb  [TABLE_DEPTH];
    int          held_count = 0;

    int   items_accepted = 0;
    int   results_seen = 0;
    int   fail_count = 0;
    int   cycle_count = 0;
    logic in_taken = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    sorted_key_table_search_delete dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_out_item table_result(t_in_item item);
        t_out_item r;
        int left;
        int right;
        int mid;
        int hit;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        case (item.action)
            ACT_APPEND: begin
                if (held_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    table_key[held_count] = item.key;
                    table_va[held_count] = item.value_a;
                    table_vb[held_count] = item.value_b;
                    r.position = POS_W'(held_count);
                    held_count++;
                end
            end
            ACT_LOOKUP, ACT_SET, ACT_WITHDRAW: begin
                left = 0;
                right = held_count - 1;
                while (left <= right && hit < 0) begin
                    mid = (left + right) / 2;
                    if (table_key[mid] < item.key) begin
                        left = mid + 1;
                    end else if (table_key[mid] > item.key) begin
                        right = mid - 1;
                    end else begin
                        hit = mid;
                    end
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    if (item.action == ACT_SET) begin
                        table_va[hit] = item.value_a;
                        table_vb[hit] = item.value_b;
                    end
                    r.position = POS_W'(hit);
                    r.found_value_a = table_va[hit];
                    r.found_value_b = table_vb[hit];
                    if (item.action == ACT_WITHDRAW) begin
                        held_count--;
                        for (int i = hit; i < held_count; i++) begin
                            table_key[i] = table_key[i + 1];
                            table_va[i] = table_va[i + 1];
                            table_vb[i] = table_vb[i + 1];
                        end
                    end
                end
            end
            ACT_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        r.average_doubled = 9'(r.found_value_a) + 9'(r.found_value_b);
        r.entries = ENT_W'(held_count);
        return r;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_item(t_action act, logic [15:0] key, logic [7:0] va, logic [7:0] vb);
        t_in_item item;
        item.action = act;
        item.key = key;
        item.value_a = va;
        item.value_b = vb;
        pending_items.push_back(item);
        case (act)
            ACT_APPEND: begin
                if (gen_keys.size() < TABLE_DEPTH) gen_keys.push_back(key);
            end
            ACT_WITHDRAW: begin
                for (int i = 0; i < gen_keys.size(); i++) begin
                    if (gen_keys[i] == key) begin
                        gen_keys.delete(i);
                        break;
                    end
                end
            end
            ACT_CLEAR: begin
                gen_keys.delete();
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [15:0] pick_key();
        if (gen_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
            return 16'(gen_keys[$urandom_range(0, gen_keys.size() - 1)]);
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly ascending keys, with the odd duplicate or out-of-order key as noise.
    function automatic int next_key(int last_key);
        int sel;
        int k;
        sel = $urandom_range(0, 19);
        if (sel == 0) return $urandom_range(0, 65535);
        if (sel == 1) return last_key;
        k = last_key + $urandom_range(1, 900);
        return (k > 65535) ? 65535 : k;
    endfunction

    task automatic build_directed();
        queue_item(ACT_LOOKUP, 16'h0000, 8'h00, 8'h00);
        queue_item(ACT_WITHDRAW, 16'hFFFF, 8'h00, 8'h00);
        queue_item(ACT_SET, 16'h1234, 8'hFF, 8'hFF);
        queue_item(ACT_CLEAR, 16'h0000, 8'h00, 8'h00);
        queue_item(ACT_APPEND, 16'h0000, 8'h00, 8'h00);
        queue_item(ACT_APPEND, 16'h7FFF, 8'hFF, 8'h00);
        queue_item(ACT_APPEND, 16'h8000, 8'h00, 8'hFF);
        queue_item(ACT_APPEND, 16'hFFFF, 8'hFF, 8'hFF);
        queue_item(ACT_LOOKUP, 16'h0000, 8'h00, 8'h00);
        queue_item(ACT_LOOKUP, 16'hFFFF, 8'h00, 8'h00);
        queue_item(ACT_LOOKUP, 16'h7FFF, 8'h00, 8'h00);
        queue_item(ACT_LOOKUP, 16'h0001, 8'h00, 8'h00);
        queue_item(ACT_LOOKUP, 16'hFFFE, 8'h00, 8'h00);
        queue_item(ACT_SET, 16'h8000, 8'hAA, 8'h55);
        queue_item(ACT_SET, 16'h1111, 8'h12, 8'h34);
        queue_item(ACT_WITHDRAW, 16'h7FFF, 8'h00, 8'h00);
        queue_item(ACT_LOOKUP, 16'h8000, 8'h00, 8'h00);
        queue_item(ACT_WITHDRAW, 16'h0000, 8'h00, 8'h00);
        queue_item(ACT_WITHDRAW, 16'hFFFF, 8'h00, 8'h00);
        for (int c = 5; c <= 7; c++) begin
            queue_item(t_action'(3'(c)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        queue_item(ACT_APPEND, 16'h8000, 8'h01, 8'h02);
        queue_item(ACT_APPEND, 16'h0010, 8'h03, 8'h04);
        queue_item(ACT_LOOKUP, 16'h0010, 8'h00, 8'h00);
        queue_item(ACT_LOOKUP, 16'h8000, 8'h00, 8'h00);
        queue_item(ACT_CLEAR, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    task automatic build_random();
        int episode;
        int fill;
        int ops;
        int sel;
        int last_key;
        episode = 0;
        while (pending_items.size() < TOTAL_ITEMS) begin
            if (episode == 0 || $urandom_range(0, 3) != 0) begin
                queue_item(ACT_CLEAR, 16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            fill = (episode % 6 == 0) ? $urandom_range(60, 70) : $urandom_range(1, 24);
            last_key = (episode % 5 == 0) ? 0 : $urandom_range(0, 2000);
            for (int k = 0; k < fill; k++) begin
                last_key = next_key(last_key);
                queue_item(ACT_APPEND, 16'(last_key),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            ops = $urandom_range(8, 40);
            for (int k = 0; k < ops; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 30) begin
                    queue_item(ACT_LOOKUP, pick_key(), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                end else if (sel < 50) begin
                    queue_item(ACT_SET, pick_key(), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                end else if (sel < 72) begin
                    queue_item(ACT_WITHDRAW, pick_key(), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                end else if (sel < 87) begin
                    last_key = next_key(last_key);
                    queue_item(ACT_APPEND, 16'(last_key),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end else if (sel < 90) begin
                    queue_item(ACT_CLEAR, 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    last_key = 0;
                end else if (sel < 95) begin
                    queue_item(t_action'(3'($urandom_range(5, 7))),
                               16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end else begin
                    queue_item(ACT_LOOKUP, pick_key() + 16'd1, 8'h00, 8'h00);
                end
            end
            episode++;
        end
    endtask

    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(table_result(i_in_item));
                items_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result item with none expected, actual %h",
                             $time, o_out_item);
                    fail_count++;
                end else begin
                    t_out_item want;
                    want = expected_results.pop_front();
                    check_field("status", 16'(want.status), 16'(o_out_item.status));
                    check_field("position", 16'(want.position), 16'(o_out_item.position));
                    check_field("found_value_a", 16'(want.found_value_a),
                                16'(o_out_item.found_value_a));
                    check_field("found_value_b", 16'(want.found_value_b),
                                16'(o_out_item.found_value_b));
                    check_field("average_doubled", 16'(want.average_doubled),
                                16'(o_out_item.average_doubled));
                    check_field("entries", 16'(want.entries), 16'(o_out_item.entries));
                end
                results_seen++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (in_taken || !i_in_valid) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (pending_items.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > CALM_TAIL && (items_accepted / 100) % 4 != 3
                         && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                gap_left = $urandom_range(0, 2);
            end else begin
                i_in_item <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            i_out_ready <= 1'b0;
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (results_seen < TOTAL_ITEMS - CALM_TAIL && (results_seen / 100) % 4 != 1
                     && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        build_directed();
        build_random();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sorted_key_table_search_delete.f
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/sorted_key_table_search_delete.sv
tb/sorted_key_table_search_delete_test.sv
